FILE: sv/gdad_pkg.sv
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, widths and calendar helpers for the date add/compare block.
// ----------------------------------------------------------------------------
package gdad_pkg;

  localparam int YEAR_MAX_DEF   = 9999;
  localparam int DELTA_BITS_DEF = 17;

  localparam int YEAR_W  = 14;  // stored / port year width
  localparam int YEAR_WK = 15;  // working year width, room above YEAR_MAX
  localparam int HUND_W  = 8;   // centuries of a working year
  localparam int MON_W   = 4;
  localparam int DAY_W   = 5;   // normalized day
  localparam int DIN_W   = 16;  // request day field

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_CMP  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    logic go;
  } norm_req_t;

  typedef struct packed {
    logic done;
    logic underflow;  // borrowed below January of year 1
    logic overflow;   // carried forward while already past YEAR_MAX
  } norm_sts_t;

  // year = 100*hund + rem, so year mod 4 equals rem mod 4
  function automatic logic is_leap(input logic [YEAR_WK-1:0] rem,
                                   input logic [HUND_W-1:0]  hund);
    if (rem == '0) begin
      is_leap = (hund[1:0] == 2'd0);
    end else begin
      is_leap = (rem[1:0] == 2'd0);
    end
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    case (m)
      4'd2:    month_len = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   month_len = 5'd30;
      default: month_len = 5'd31;
    endcase
  endfunction

endpackage

FILE: sv/gdad_norm.sv
// ----------------------------------------------------------------------------
// gdad_norm
// Iterative date normalizer: splits the year into centuries, then moves the
// day count one month per cycle through a single shared adder.
// ----------------------------------------------------------------------------
module gdad_norm #(
  parameter int YEAR_MAX = gdad_pkg::YEAR_MAX_DEF,
  parameter int WDAY_W   = 18
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gdad_pkg::norm_req_t               req,
  input  logic [gdad_pkg::YEAR_WK-1:0]      req_year,
  input  logic [gdad_pkg::MON_W-1:0]        req_month,
  input  logic signed [WDAY_W-1:0]          req_day,
  output gdad_pkg::norm_sts_t               sts,
  output logic [gdad_pkg::YEAR_WK-1:0]      norm_year,
  output logic [gdad_pkg::MON_W-1:0]        norm_month,
  output logic signed [WDAY_W-1:0]          norm_day
);
  import gdad_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPLIT,
    S_STEP,
    S_DONE
  } state_t;

  localparam logic [YEAR_WK-1:0] YMAX   = YEAR_WK'(YEAR_MAX);
  localparam logic [YEAR_WK-1:0] CENT   = YEAR_WK'(100);
  localparam logic [YEAR_WK-1:0] LAST_R = YEAR_WK'(99);

  state_t                    state_r, state_nxt;
  logic [YEAR_WK-1:0]        year_r, year_nxt;
  logic [YEAR_WK-1:0]        rem_r, rem_nxt;
  logic [HUND_W-1:0]         hund_r, hund_nxt;
  logic [MON_W-1:0]          mon_r, mon_nxt;
  logic signed [WDAY_W-1:0]  day_r, day_nxt;
  logic                      under_r, under_nxt;
  logic                      over_r, over_nxt;

  logic                      leap_cur, leap_prev, wrap;
  logic [DAY_W-1:0]          len_cur, len_prev;
  logic [MON_W-1:0]          prev_mon;
  logic [YEAR_WK-1:0]        prev_rem;
  logic [HUND_W-1:0]         prev_hund;
  logic signed [WDAY_W-1:0]  len_cur_s, addend, day_sum;
  logic                      fwd, back;

  // month length of the current month and of the one before it
  always_comb begin
    wrap      = (mon_r == 4'd1);
    prev_mon  = wrap ? 4'd12 : mon_r - 4'd1;
    prev_rem  = (rem_r == '0) ? LAST_R : rem_r - 1'b1;
    prev_hund = (rem_r == '0) ? hund_r - 1'b1 : hund_r;
    leap_cur  = is_leap(rem_r, hund_r);
    leap_prev = wrap ? is_leap(prev_rem, prev_hund) : leap_cur;
    len_cur   = month_len(mon_r, leap_cur);
    len_prev  = month_len(prev_mon, leap_prev);
    len_cur_s = $signed({{(WDAY_W-DAY_W){1'b0}}, len_cur});
    fwd       = (day_r > len_cur_s);
    back      = day_r[WDAY_W-1] || (day_r == '0);
    // shared adder: subtract on carry, add previous length on borrow
    addend    = fwd ? -len_cur_s : $signed({{(WDAY_W-DAY_W){1'b0}}, len_prev});
    day_sum   = day_r + addend;
  end

  always_comb begin
    state_nxt = state_r;
    year_nxt  = year_r;
    rem_nxt   = rem_r;
    hund_nxt  = hund_r;
    mon_nxt   = mon_r;
    day_nxt   = day_r;
    under_nxt = under_r;
    over_nxt  = over_r;
    case (state_r)
      S_IDLE: begin
        if (req.go) begin
          year_nxt  = req_year;
          rem_nxt   = req_year;
          hund_nxt  = '0;
          mon_nxt   = req_month;
          day_nxt   = req_day;
          under_nxt = 1'b0;
          over_nxt  = 1'b0;
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (rem_r >= CENT) begin
          rem_nxt  = rem_r - CENT;
          hund_nxt = hund_r + 1'b1;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (fwd) begin
          if (year_r > YMAX) begin
            over_nxt  = 1'b1;   // only moves further out
            state_nxt = S_DONE;
          end else begin
            day_nxt = day_sum;
            if (mon_r == 4'd12) begin
              mon_nxt  = 4'd1;
              year_nxt = year_r + 1'b1;
              if (rem_r == LAST_R) begin
                rem_nxt  = '0;
                hund_nxt = hund_r + 1'b1;
              end else begin
                rem_nxt = rem_r + 1'b1;
              end
            end else begin
              mon_nxt = mon_r + 4'd1;
            end
          end
        end else if (back) begin
          if (wrap && (year_r == YEAR_WK'(1))) begin
            under_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            day_nxt = day_sum;
            mon_nxt = prev_mon;
            if (wrap) begin
              year_nxt = year_r - 1'b1;
              rem_nxt  = prev_rem;
              hund_nxt = prev_hund;
            end
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      under_r <= 1'b0;
      over_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      under_r <= under_nxt;
      over_r  <= over_nxt;
    end
    year_r <= year_nxt;
    rem_r  <= rem_nxt;
    hund_r <= hund_nxt;
    mon_r  <= mon_nxt;
    day_r  <= day_nxt;
  end

  assign sts.done      = (state_r == S_DONE);
  assign sts.underflow = under_r;
  assign sts.overflow  = over_r;
  assign norm_year     = year_r;
  assign norm_month    = mon_r;
  assign norm_day      = day_r;

endmodule

FILE: sv/gregorian_date_add_days.sv
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Flow: ops that need no normalization (bad operand, op 3) strobe the result
//   in the cycle after they are accepted; otherwise the normalizer splits the
//   year into centuries, then moves the day one month per cycle in its adder.
// Throughput: one request at a time; busy is high from the accept edge up to
//   the result strobe, and a new request can be taken in the strobe cycle.
// Reset: synchronous active-low; stored date returns to 1/1/2000.
// ----------------------------------------------------------------------------
module gregorian_date_add_days #(
  parameter int YEAR_MAX   = gdad_pkg::YEAR_MAX_DEF,
  parameter int DELTA_BITS = gdad_pkg::DELTA_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_operation,
  input  logic signed [gdad_pkg::DIN_W-1:0] in_date_day,
  input  logic [gdad_pkg::MON_W-1:0]       in_date_month,
  input  logic [gdad_pkg::YEAR_W-1:0]      in_date_year,
  input  logic signed [DELTA_BITS-1:0]     in_day_delta,
  // result channel, one-cycle strobe, no back-pressure
  output logic                             out_valid,
  output logic [gdad_pkg::DAY_W-1:0]       out_result_day,
  output logic [gdad_pkg::MON_W-1:0]       out_result_month,
  output logic [gdad_pkg::YEAR_W-1:0]      out_result_year,
  output logic                             out_range_error,
  output logic                             out_is_before,
  output logic                             out_is_same,
  output logic                             out_is_after
);
  import gdad_pkg::*;

  // working day count must hold a 16-bit request day or day+delta
  localparam int WDAY_W = ((DELTA_BITS > DIN_W) ? DELTA_BITS : DIN_W) + 1;
  localparam logic [YEAR_WK-1:0] YMAX = YEAR_WK'(YEAR_MAX);

  typedef enum logic {
    T_IDLE,
    T_RUN
  } tstate_t;

  tstate_t               state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [DAY_W-1:0]      cur_day_r, cur_day_nxt;
  logic [MON_W-1:0]      cur_mon_r, cur_mon_nxt;
  logic [YEAR_W-1:0]     cur_year_r, cur_year_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  rerr_r, rerr_nxt;
  logic                  before_r, before_nxt;
  logic                  same_r, same_nxt;
  logic                  after_r, after_nxt;
  logic [DAY_W-1:0]      oday_r;
  logic [MON_W-1:0]      omon_r;
  logic [YEAR_W-1:0]     oyear_r;

  // request decode
  op_t                   in_op;
  logic                  accept, in_ok, need_norm;
  norm_req_t             nreq;
  logic [YEAR_WK-1:0]    req_year;
  logic [MON_W-1:0]      req_month;
  logic signed [WDAY_W-1:0] req_day;

  norm_sts_t             nsts;
  logic [YEAR_WK-1:0]    n_year;
  logic [MON_W-1:0]      n_mon;
  logic signed [WDAY_W-1:0] n_day;

  logic                  reject, n_lt, n_eq;
  logic [YEAR_WK-1:0]    cur_year_wk;
  logic [DAY_W-1:0]      n_day5;

  assign in_op  = op_t'(in_operation);
  assign accept = start && !busy;
  assign in_ok  = (in_date_month >= 4'd1) && (in_date_month <= 4'd12) &&
                  (in_date_year != '0);
  assign need_norm = (in_op == OP_ADD) ||
                     (((in_op == OP_LOAD) || (in_op == OP_CMP)) && in_ok);

  // add works from the stored date, load/compare from the request date
  always_comb begin
    if (in_op == OP_ADD) begin
      req_year  = {1'b0, cur_year_r};
      req_month = cur_mon_r;
      req_day   = $signed({{(WDAY_W-DAY_W){1'b0}}, cur_day_r}) +
                  $signed({{(WDAY_W-DELTA_BITS){in_day_delta[DELTA_BITS-1]}},
                           in_day_delta});
    end else begin
      req_year  = {1'b0, in_date_year};
      req_month = in_date_month;
      req_day   = $signed({{(WDAY_W-DIN_W){in_date_day[DIN_W-1]}}, in_date_day});
    end
    nreq.go = accept && need_norm;
  end

  gdad_norm #(
    .YEAR_MAX (YEAR_MAX),
    .WDAY_W   (WDAY_W)
  ) u_norm (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (nreq),
    .req_year   (req_year),
    .req_month  (req_month),
    .req_day    (req_day),
    .sts        (nsts),
    .norm_year  (n_year),
    .norm_month (n_mon),
    .norm_day   (n_day)
  );

  // normalized date vs stored date, lexicographic on (year, month, day)
  assign cur_year_wk = {1'b0, cur_year_r};
  assign n_day5      = n_day[DAY_W-1:0];
  assign n_eq = (n_year == cur_year_wk) && (n_mon == cur_mon_r) &&
                (n_day5 == cur_day_r);
  assign n_lt = (n_year < cur_year_wk) ||
                ((n_year == cur_year_wk) && (n_mon < cur_mon_r)) ||
                ((n_year == cur_year_wk) && (n_mon == cur_mon_r) &&
                 (n_day5 < cur_day_r));
  // year leaves 1..YEAR_MAX: keep the stored date
  assign reject = nsts.underflow || nsts.overflow || (n_year > YMAX);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cur_day_nxt   = cur_day_r;
    cur_mon_nxt   = cur_mon_r;
    cur_year_nxt  = cur_year_r;
    out_valid_nxt = 1'b0;
    rerr_nxt      = rerr_r;
    before_nxt    = before_r;
    same_nxt      = same_r;
    after_nxt     = after_r;
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          op_nxt = in_op;
          if (need_norm) begin
            state_nxt = T_RUN;
          end else begin
            // bad operand or unused op: answer at once
            out_valid_nxt = 1'b1;
            rerr_nxt      = (in_op == OP_LOAD);
            before_nxt    = 1'b0;
            same_nxt      = 1'b0;
            after_nxt     = 1'b0;
          end
        end
      end
      T_RUN: begin
        if (nsts.done) begin
          state_nxt     = T_IDLE;
          out_valid_nxt = 1'b1;
          rerr_nxt      = 1'b0;
          before_nxt    = 1'b0;
          same_nxt      = 1'b0;
          after_nxt     = 1'b0;
          if (op_r == OP_CMP) begin
            // input past the year range is later, below year 1 earlier
            before_nxt = nsts.overflow || (!nsts.underflow && !n_lt && !n_eq);
            after_nxt  = nsts.underflow || (!nsts.overflow && n_lt);
            same_nxt   = !nsts.underflow && !nsts.overflow && n_eq;
          end else begin
            rerr_nxt = reject;
            if (!reject) begin
              cur_day_nxt  = n_day5;
              cur_mon_nxt  = n_mon;
              cur_year_nxt = n_year[YEAR_W-1:0];
            end
          end
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      op_r        <= OP_NONE;
      cur_day_r   <= DAY_W'(1);
      cur_mon_r   <= MON_W'(1);
      cur_year_r  <= YEAR_W'(2000);
      out_valid_r <= 1'b0;
      rerr_r      <= 1'b0;
      before_r    <= 1'b0;
      same_r      <= 1'b0;
      after_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cur_day_r   <= cur_day_nxt;
      cur_mon_r   <= cur_mon_nxt;
      cur_year_r  <= cur_year_nxt;
      out_valid_r <= out_valid_nxt;
      rerr_r      <= rerr_nxt;
      before_r    <= before_nxt;
      same_r      <= same_nxt;
      after_r     <= after_nxt;
    end
    // result date is the stored date after this request
    oday_r  <= cur_day_nxt;
    omon_r  <= cur_mon_nxt;
    oyear_r <= cur_year_nxt;
  end

  assign busy             = (state_r == T_RUN);
  assign out_valid        = out_valid_r;
  assign out_result_day   = oday_r;
  assign out_result_month = omon_r;
  assign out_result_year  = oyear_r;
  assign out_range_error  = rerr_r;
  assign out_is_before    = before_r;
  assign out_is_same      = same_r;
  assign out_is_after     = after_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_is_before, out_is_same, out_is_after}))
    else $error("compare flags not exclusive");

  a_err_vs_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |->
      !(out_is_before || out_is_same || out_is_after))
    else $error("range error together with compare flag");

  a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == OP_NONE)) |=> (out_valid && !busy))
    else $error("unused op did not answer next cycle");

  a_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_result_month >= 4'd1) && (out_result_month <= 4'd12) &&
                   (out_result_day != '0) && (out_result_year != '0)))
    else $error("reported date not normalized");

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// gregorian_date_add_days testbench
// Sends date loads, day additions, compares and no-op requests through the
// start/busy port and predicts every stored date and flag on the fly from a
// day-count model of the proleptic Gregorian calendar. Each out_valid strobe
// is checked field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
  import gdad_pkg::*;

  localparam int CAL_YEAR_MAX = YEAR_MAX_DEF;
  localparam int DELTA_W      = DELTA_BITS_DEF;

  // day counts of the calendar cycles
  localparam longint DAYS_PER_400Y = 146097;
  localparam longint DAYS_PER_100Y = 36524;
  localparam longint DAYS_PER_4Y   = 1461;
  localparam longint DAYS_PER_YEAR = 365;

  // day of year (0 based) on which each month starts, common year
  localparam longint MONTH_OFFSET [12] = '{0, 31, 59, 90, 120, 151, 181, 212,
                                           243, 273, 304, 334};

  // settle window, set above the longest single request
  localparam int SETTLE_CYCLES = 2500;
  localparam int PRINT_CAP     = 50;

  // --------------------------------------------------------------------------
  // DUT and its ports, every input known from time zero
  // --------------------------------------------------------------------------
  logic                       clk           = 1'b0;
  logic                       rst_n         = 1'b0;
  logic                       start         = 1'b0;
  logic                       busy;
  logic [1:0]                 in_operation  = OP_NONE;
  logic signed [DIN_W-1:0]    in_date_day   = '0;
  logic [MON_W-1:0]           in_date_month = '0;
  logic [YEAR_W-1:0]          in_date_year  = '0;
  logic signed [DELTA_W-1:0]  in_day_delta  = '0;
  logic                       out_valid;
  logic [DAY_W-1:0]           out_result_day;
  logic [MON_W-1:0]           out_result_month;
  logic [YEAR_W-1:0]          out_result_year;
  logic                       out_range_error;
  logic                       out_is_before;
  logic                       out_is_same;
  logic                       out_is_after;

  gregorian_date_add_days dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_date_day      (in_date_day),
    .in_date_month    (in_date_month),
    .in_date_year     (in_date_year),
    .in_day_delta     (in_day_delta),
    .out_valid        (out_valid),
    .out_result_day   (out_result_day),
    .out_result_month (out_result_month),
    .out_result_year  (out_result_year),
    .out_range_error  (out_range_error),
    .out_is_before    (out_is_before),
    .out_is_same      (out_is_same),
    .out_is_after     (out_is_after)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Calendar predictor: the date is held as a serial day count from 1/1/1
  // --------------------------------------------------------------------------
  typedef struct {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic              range_error;
    logic              is_before;
    logic              is_same;
    logic              is_after;
  } date_result_t;

  // stored date as the DUT should hold it after the last accepted request
  logic [DAY_W-1:0]  held_day   = 5'd1;
  logic [MON_W-1:0]  held_month = 4'd1;
  logic [YEAR_W-1:0] held_year  = 14'd2000;

  date_result_t pending_dates[$];
  int           mismatch_count = 0;

  function automatic bit leap_year_of(input longint y);
    return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
  endfunction

  function automatic longint days_in_month(input longint m, input longint y);
    if (m == 2) return leap_year_of(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  // month must be 1..12 and year at least 1; day may lie outside the month
  function automatic longint day_serial(input longint y, input longint m,
                                        input longint d);
    longint p;
    longint s;
    p = y - 1;
    s = 365 * p + p / 4 - p / 100 + p / 400 + MONTH_OFFSET[m - 1];
    if (m > 2 && leap_year_of(y)) s = s + 1;
    return s + d - 1;
  endfunction

  // split a serial back into day/month/year: 400, 100, 4 and 1 year cycles, the last
  // century of each 400 and the last year of each 4 year cycle absorbing the leap day
  function automatic void hold_serial(input longint s);
    longint r;
    longint n400;
    longint n100;
    longint n4;
    longint n1;
    longint yr;
    longint mo;
    n400 = s / DAYS_PER_400Y;
    r    = s % DAYS_PER_400Y;
    n100 = r / DAYS_PER_100Y;
    if (n100 == 4) n100 = 3;
    r    = r - n100 * DAYS_PER_100Y;
    n4   = r / DAYS_PER_4Y;
    r    = r % DAYS_PER_4Y;
    n1   = r / DAYS_PER_YEAR;
    if (n1 == 4) n1 = 3;
    r    = r - n1 * DAYS_PER_YEAR;
    yr   = 400 * n400 + 100 * n100 + 4 * n4 + n1 + 1;
    mo   = 1;
    while (mo < 12 && r >= days_in_month(mo, yr)) begin
      r  = r - days_in_month(mo, yr);
      mo = mo + 1;
    end
    held_day   = DAY_W'(r + 1);
    held_month = MON_W'(mo);
    held_year  = YEAR_W'(yr);
  endfunction

  // returns 1 when the serial falls outside years 1..YEAR_MAX (date kept)
  function automatic bit store_if_in_range(input longint s);
    if (s < 0 || s > day_serial(CAL_YEAR_MAX + 1, 1, 1) - 1) return 1'b1;
    hold_serial(s);
    return 1'b0;
  endfunction

  function automatic date_result_t predict_date(input op_t op,
      input logic signed [DIN_W-1:0] day, input logic [MON_W-1:0] month,
      input logic [YEAR_W-1:0] year, input logic signed [DELTA_W-1:0] delta);
    date_result_t r;
    bit           operand_ok;
    longint       held_s;
    longint       in_s;
    longint       day_l;
    longint       delta_l;
    longint       month_l;
    longint       year_l;
    day_l         = longint'(day);
    delta_l       = longint'(delta);
    month_l       = longint'(month);
    year_l        = longint'(year);
    r.range_error = 1'b0;
    r.is_before   = 1'b0;
    r.is_same     = 1'b0;
    r.is_after    = 1'b0;
    operand_ok    = month_l >= 1 && month_l <= 12 && year_l != 0;
    case (op)
      OP_LOAD: begin
        if (!operand_ok) r.range_error = 1'b1;
        else r.range_error = store_if_in_range(day_serial(year_l, month_l, day_l));
      end
      OP_ADD: begin
        held_s        = day_serial(longint'(held_year), longint'(held_month),
                                   longint'(held_day));
        r.range_error = store_if_in_range(held_s + delta_l);
      end
      OP_CMP: begin
        if (operand_ok) begin
          // no range check on the compared date, plain day counts
          held_s      = day_serial(longint'(held_year), longint'(held_month),
                                   longint'(held_day));
          in_s        = day_serial(year_l, month_l, day_l);
          r.is_before = held_s < in_s;
          r.is_same   = held_s == in_s;
          r.is_after  = held_s > in_s;
        end
      end
      default: ;
    endcase
    r.day   = held_day;
    r.month = held_month;
    r.year  = held_year;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: one strobe per request, in request order
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    date_result_t want;
    if (rst_n && out_valid) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("result with no request pending", 64'sd1, 64'sd0);
      end else begin
        want = pending_dates.pop_front();
        if (out_result_day !== want.day)
          report_mismatch("result_day", longint'(out_result_day),
                          longint'(want.day));
        if (out_result_month !== want.month)
          report_mismatch("result_month", longint'(out_result_month),
                          longint'(want.month));
        if (out_result_year !== want.year)
          report_mismatch("result_year", longint'(out_result_year),
                          longint'(want.year));
        if (out_range_error !== want.range_error)
          report_mismatch("range_error", longint'(out_range_error),
                          longint'(want.range_error));
        if (out_is_before !== want.is_before)
          report_mismatch("is_before", longint'(out_is_before),
                          longint'(want.is_before));
        if (out_is_same !== want.is_same)
          report_mismatch("is_same", longint'(out_is_same),
                          longint'(want.is_same));
        if (out_is_after !== want.is_after)
          report_mismatch("is_after", longint'(out_is_after),
                          longint'(want.is_after));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side. Called right after a rising edge. start is left high on
  // return so back-to-back requests never drop it; pauses lower it.
  // --------------------------------------------------------------------------
  task automatic send_request(input op_t op, input logic signed [DIN_W-1:0] day,
      input logic [MON_W-1:0] month, input logic [YEAR_W-1:0] year,
      input logic signed [DELTA_W-1:0] delta);
    start         <= 1'b1;
    in_operation  <= op;
    in_date_day   <= day;
    in_date_month <= month;
    in_date_year  <= year;
    in_day_delta  <= delta;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge: busy sampled low with start high
    pending_dates.push_back(predict_date(op, day, month, year, delta));
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every pending result is back; waits on the clock even when none is pending
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_dates.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // fresh out of reset: stored date must be 1/1/2000; no-op reports it as is
  task automatic test_reset_date();
    send_request(OP_NONE, 16'sh7fff, 4'd15, 14'h3fff, 17'sh0ffff);
    send_request(OP_CMP, 16'sd1, 4'd1, 14'd2000, '0);
    drain_results();
  endtask

  // loads: year extremes, day carry/borrow across leap rules, bad operands
  task automatic test_load_normalize();
    send_request(OP_LOAD, 16'sd1, 4'd1, 14'd1, '0);
    send_request(OP_LOAD, 16'sd0, 4'd3, 14'd2000, '0);      // -> 29 Feb 2000
    send_request(OP_LOAD, 16'sd29, 4'd2, 14'd1900, '0);     // -> 1 Mar 1900
    send_request(OP_LOAD, 16'sh7fff, 4'd12, 14'd9999, '0);  // past 9999
    send_request(OP_LOAD, 16'sh8000, 4'd1, 14'd9999, '0);   // long borrow, ok
    send_request(OP_LOAD, 16'sd5, 4'd0, 14'd2000, '0);      // month 0
    send_request(OP_LOAD, 16'sd5, 4'd15, 14'd2000, '0);     // month 15
    send_request(OP_LOAD, 16'sd5, 4'd6, 14'd0, '0);         // year 0
    send_request(OP_LOAD, 16'sd1, 4'd1, 14'h3fff, '0);      // year too big
    drain_results();
  endtask

  // adds: century non-leap year, full delta swing, both range edges
  task automatic test_add_delta();
    send_request(OP_LOAD, 16'sd28, 4'd2, 14'd2100, '0);
    send_request(OP_ADD, '0, '0, '0, 17'sd1);               // -> 1 Mar 2100
    send_request(OP_ADD, '0, '0, '0, 17'sh0ffff);
    send_request(OP_ADD, '0, '0, '0, 17'sh10000);
    send_request(OP_ADD, '0, '0, '0, '0);
    send_request(OP_LOAD, 16'sd31, 4'd12, 14'd9999, '0);
    send_request(OP_ADD, '0, '0, '0, 17'sd1);               // off the top
    send_request(OP_LOAD, 16'sd1, 4'd1, 14'd1, '0);
    send_request(OP_ADD, '0, '0, '0, -17'sd1);              // off the bottom
    drain_results();
  endtask

  // compares against 1/1/1: both orders, bad operands, date beyond 9999
  task automatic test_compare_dates();
    send_request(OP_CMP, 16'sd2, 4'd1, 14'd1, '0);
    send_request(OP_CMP, 16'sd0, 4'd1, 14'd1, '0);          // day before 1/1/1
    send_request(OP_CMP, 16'sd1, 4'd13, 14'd1, '0);
    send_request(OP_CMP, 16'sd1, 4'd1, 14'd0, '0);
    send_request(OP_CMP, 16'sd1, 4'd1, 14'h3fff, '0);
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Random traffic. Mostly valid loads, adds and compares so the stored date
  // wanders through the whole calendar; some raw noise for bad operands.
  // --------------------------------------------------------------------------
  task automatic send_random_request();
    op_t                      op;
    logic signed [DIN_W-1:0]  day;
    logic [MON_W-1:0]         month;
    logic [YEAR_W-1:0]        year;
    logic signed [DELTA_W-1:0] delta;
    int                       kind;
    int                       pick;
    kind  = int'($urandom_range(99));
    pick  = int'($urandom_range(99));
    op    = OP_LOAD;
    day   = DIN_W'($urandom);
    month = MON_W'($urandom);
    year  = YEAR_W'($urandom);
    delta = DELTA_W'($urandom);
    if (kind < 30) begin
      month = MON_W'($urandom_range(1, 12));
      if (pick < 15) year = ($urandom_range(1) != 0) ? YEAR_W'($urandom_range(1, 3))
                                                      : YEAR_W'($urandom_range(9997, 9999));
      else year = YEAR_W'($urandom_range(1, CAL_YEAR_MAX));
      if (pick % 5 != 0) day = DIN_W'($urandom_range(0, 32));
    end else if (kind < 36) begin
      // raw fields: bad months, year 0 or beyond range, wild days
      if (pick < 30) year = '0;
    end else if (kind < 76) begin
      op = OP_ADD;
      if (pick < 50) delta = DELTA_W'(int'($urandom_range(0, 800)) - 400);
      else if (pick < 80) delta = DELTA_W'(int'($urandom_range(0, 40000)) - 20000);
    end else if (kind < 95) begin
      op    = OP_CMP;
      month = MON_W'($urandom_range(1, 12));
      if (pick < 40) begin
        day   = DIN_W'(held_day);
        month = held_month;
        year  = held_year;
      end else if (pick < 70) begin
        day   = DIN_W'(int'(held_day) + int'($urandom_range(0, 4)) - 2);
        month = held_month;
        year  = held_year;
      end else if (pick < 85) begin
        year = YEAR_W'($urandom_range(1, CAL_YEAR_MAX));
      end
    end else begin
      op = ($urandom_range(1) != 0) ? OP_NONE : OP_CMP;
    end
    send_request(op, day, month, year, delta);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct);
    repeat (count) begin
      if (idle_pct != 0 && $urandom_range(99) < 3) drain_results();
      else if ($urandom_range(99) < idle_pct) pause_sender(int'($urandom_range(1, 12)));
      send_random_request();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_date();
    test_load_normalize();
    test_add_delta();
    test_compare_dates();
    test_random_traffic(75, 6);
    test_random_traffic(75, 61);
    test_random_traffic(75, 0);

    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    // catch any stray strobe after the last result
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[gregorian_date_add_days] OK");
    end else begin
      $display("[gregorian_date_add_days] ERROR");
    end
    $finish;
  end

  // several times the slowest legal run: every request at worst-case latency
  initial begin
    #25_000_000;
    $display("[gregorian_date_add_days] ERROR");
    $finish;
  end

endmodule

FILE: files.f
sv/gdad_pkg.sv
sv/gdad_norm.sv
sv/gregorian_date_add_days.sv
dv/testbench.sv
